### src/edh_pkg.sv
// Package: widths, register indexes, payload types and arithmetic helpers for the halftone unit.
`default_nettype none

package edh_pkg;

  // Row store depth and index width
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Field widths
  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int LW_W       = 11;
  localparam int ERR_W      = 10;
  localparam int CALC_W     = 16;
  localparam int CMP_W      = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(1);

  // Reset values and limits
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);
  localparam logic [LW_W-1:0]  LW_RESET  = LW_W'(256);
  localparam logic [CMP_W-1:0] LW_MIN    = CMP_W'(2);
  localparam logic [CMP_W-1:0] LW_MAX    = CMP_W'(MAX_WIDTH);

  // Dot codes
  localparam logic [PIX_W-1:0] DOT_WHITE = PIX_W'(8'hFF);
  localparam logic [PIX_W-1:0] DOT_BLACK = PIX_W'(0);
  localparam logic signed [CALC_W-1:0] WHITE_LEVEL = CALC_W'(255);

  localparam logic signed [CALC_W-1:0] ERR_HI = CALC_W'(511);
  localparam logic signed [CALC_W-1:0] ERR_LO = -CALC_W'(512);

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [CALC_W-1:0] calc_t;

  // Pixel in flight between the front end and the diffusion step
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             last;
    logic             first_row;
    logic             sof;
  } item_t;

  // Row store write request
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    err_t             data;
  } st_wr_t;

  // Divide by 16 with truncation toward zero
  function automatic calc_t div16_trunc(input calc_t p);
    calc_t bias;
    calc_t sum;
    bias = {{(CALC_W-4){1'b0}}, {4{p[CALC_W-1]}}};
    sum  = p + bias;
    return sum >>> 4;
  endfunction

  // Saturate to the error range
  function automatic err_t sat_err(input calc_t v);
    err_t r;
    if (v > ERR_HI) begin
      r = ERR_HI[ERR_W-1:0];
    end else if (v < ERR_LO) begin
      r = ERR_LO[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/edh_in_if.sv
// Interface: pixel input channel.
`default_nettype none

interface edh_in_if;
  logic                     valid;
  logic                     ready;
  logic [edh_pkg::PIX_W-1:0] pixel;
  logic                     start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

`default_nettype wire

### src/edh_out_if.sv
// Interface: halftone dot output channel.
`default_nettype none

interface edh_out_if;
  logic                     valid;
  logic                     ready;
  logic [edh_pkg::PIX_W-1:0] dot;
  logic                     end_of_line;

  modport source (output valid, output dot, output end_of_line, input ready);
  modport sink   (input valid, input dot, input end_of_line, output ready);
endinterface

`default_nettype wire

### src/edh_cfg_if.sv
// Interface: configuration register write channel.
`default_nettype none

interface edh_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [edh_pkg::CFG_IDX_W-1:0]  index;
  logic [edh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/edh_row_store.sv
// Row error store: synchronous memory with a deferred end-of-row write and read forwarding.
`default_nettype none

module edh_row_store (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [edh_pkg::COL_W-1:0] rd_addr,
  output      edh_pkg::err_t             rd_data,
  input  wire edh_pkg::st_wr_t           wr_main,
  input  wire edh_pkg::st_wr_t           wr_tail
);
  import edh_pkg::*;

  err_t   mem [MAX_WIDTH];
  err_t   mem_q_r;
  logic   fwd_hit_r;
  err_t   fwd_data_r;
  st_wr_t tail_r;
  st_wr_t tail_nxt;
  st_wr_t wr;

  // Main write wins the port; the held end-of-row entry goes in the next free cycle
  always_comb begin
    if (wr_main.en) begin
      wr = wr_main;
    end else begin
      wr = tail_r;
    end
    tail_nxt = tail_r;
    if (wr_tail.en) begin
      tail_nxt = wr_tail;
    end else if (!wr_main.en) begin
      tail_nxt.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r.en <= 1'b0;
    end else begin
      tail_r.en <= tail_nxt.en;
    end
    tail_r.addr <= tail_nxt.addr;
    tail_r.data <= tail_nxt.data;
  end

  // Memory array: write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit_r  <= wr.en && (wr.addr == rd_addr);
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : mem_q_r;

endmodule

`default_nettype wire

### src/edh_diffuse.sv
// Diffusion step: threshold compare, error split and the in-row error registers.
`default_nettype none

module edh_diffuse (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire edh_pkg::item_t            item,
  input  wire edh_pkg::err_t             above_raw,
  input  wire logic [edh_pkg::THR_W-1:0] threshold,
  output      logic [edh_pkg::PIX_W-1:0] dot,
  output      edh_pkg::st_wr_t           wr_main,
  output      edh_pkg::st_wr_t           wr_tail
);
  import edh_pkg::*;

  err_t  right_error_r, right_error_nxt;
  err_t  pend_bl_r, pend_bl_nxt;
  err_t  pend_b_r, pend_b_nxt;
  err_t  right_in, pend_bl_in, pend_b_in, above;
  calc_t v, e, s7, s5, s3, s1;
  logic  white;

  always_comb begin
    // Start of frame clears the carried errors before this pixel
    right_in   = item.sof ? '0 : right_error_r;
    pend_bl_in = item.sof ? '0 : pend_bl_r;
    pend_b_in  = item.sof ? '0 : pend_b_r;
    above      = item.first_row ? '0 : above_raw;

    v = CALC_W'($signed({1'b0, item.pixel})) + CALC_W'(right_in) + CALC_W'(above);
    white = v > CALC_W'($signed({1'b0, threshold}));
    e   = white ? v - WHITE_LEVEL : v;
    dot = white ? DOT_WHITE : DOT_BLACK;

    // Shares of the residual, each truncated toward zero
    s7 = div16_trunc(CALC_W'(e * 7));
    s5 = div16_trunc(CALC_W'(e * 5));
    s3 = div16_trunc(CALC_W'(e * 3));
    s1 = div16_trunc(e);

    wr_main.en   = adv && (item.col != '0);
    wr_main.addr = item.col - COL_W'(1);
    wr_main.data = sat_err(CALC_W'(pend_bl_in) + s3);

    pend_bl_nxt     = sat_err(CALC_W'(pend_b_in) + s5);
    pend_b_nxt      = sat_err(s1);
    right_error_nxt = sat_err(s7);

    wr_tail.en   = adv && item.last;
    wr_tail.addr = item.col;
    wr_tail.data = pend_bl_nxt;
  end

  // Advance the carried errors; drop them at the end of a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_error_r <= '0;
      pend_bl_r     <= '0;
      pend_b_r      <= '0;
    end else if (adv) begin
      if (item.last) begin
        right_error_r <= '0;
        pend_bl_r     <= '0;
        pend_b_r      <= '0;
      end else begin
        right_error_r <= right_error_nxt;
        pend_bl_r     <= pend_bl_nxt;
        pend_b_r      <= pend_b_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### src/error_diffusion_halftone_unit.sv
// Top level: error-diffusion halftone unit with front end, row store and output register.
//
// Usage: gray pixels enter in raster order on in_ch (valid/ready), start_of_frame set on
// the first pixel of each image. Each accepted pixel yields one transfer on out_ch: dot
// is 0 or 255, end_of_line marks the last pixel of a row. cfg_ch writes the threshold
// (index 0) and the line width (index 1); it is always ready and must be used only
// while no pixel is in flight.
// An accepted pixel is registered in the front stage, then its result in the output
// register that drives out_ch. Throughput: one pixel per cycle unless out_ch stalls,
// set by the right-neighbour error loop in the diffusion step and by the single
// write port of the row store, which takes the end-of-row entry in the next free cycle.
// The front end issues the row store read on acceptance; the diffusion step uses the
// registered data when the front stage advances and loads the output register.
// Reset: threshold 128, line width 256, column 0, first row; no clearing pass, the row
// store is written before it is read. When the receiver stalls, the result holds in the
// output register, one more pixel may wait in the front stage, then in_ch.ready drops.
`default_nettype none

module error_diffusion_halftone_unit (
  input wire logic clk,
  input wire logic rst_n,
  edh_in_if.sink    in_ch,
  edh_out_if.source out_ch,
  edh_cfg_if.sink   cfg_ch
);
  import edh_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic [LW_W-1:0]  line_width_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             first_row_r, first_row_nxt;
  logic             s1_valid_r;
  item_t            s1_r, item_a;
  logic             out_valid_r;
  logic [PIX_W-1:0] dot_r;
  logic             eol_r;
  logic             accept, s1_adv;
  logic [CMP_W-1:0] width_a, col_p1;
  logic [PIX_W-1:0] dot_c;
  err_t             above;
  st_wr_t           wr_main, wr_tail;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THR_RESET;
      line_width_r <= LW_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_THRESHOLD:  threshold_r  <= cfg_ch.data[THR_W-1:0];
        REG_LINE_WIDTH: line_width_r <= LW_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Handshake
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;

  // Front end: column, row flags and end-of-row decision
  always_comb begin
    width_a = CMP_W'(line_width_r);
    if (width_a < LW_MIN) begin
      width_a = LW_MIN;
    end else if (width_a > LW_MAX) begin
      width_a = LW_MAX;
    end
    item_a.pixel     = in_ch.pixel;
    item_a.sof       = in_ch.start_of_frame;
    item_a.col       = in_ch.start_of_frame ? '0 : col_r;
    item_a.first_row = in_ch.start_of_frame ? 1'b1 : first_row_r;
    col_p1           = CMP_W'(item_a.col) + CMP_W'(1);
    item_a.last      = col_p1 >= width_a;
    col_nxt          = item_a.last ? '0 : col_p1[COL_W-1:0];
    first_row_nxt    = item_a.last ? 1'b0 : item_a.first_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r       <= col_nxt;
        first_row_r <= first_row_nxt;
      end
      if (in_ch.ready) begin
        s1_valid_r <= accept;
      end
    end
  end

  // Hold the pixel while its row store read is in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item_a;
    end
  end

  edh_row_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (item_a.col),
    .rd_data (above),
    .wr_main (wr_main),
    .wr_tail (wr_tail)
  );

  edh_diffuse u_diffuse (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .item      (s1_r),
    .above_raw (above),
    .threshold (threshold_r),
    .dot       (dot_c),
    .wr_main   (wr_main),
    .wr_tail   (wr_tail)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dot_r <= dot_c;
      eol_r <= s1_r.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dot         = dot_r;
  assign out_ch.end_of_line = eol_r;

`ifndef SYNTH
  a_dot_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (dot_r == DOT_WHITE || dot_r == DOT_BLACK))
    else $error("dot is neither black nor white");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item_a.last |=> col_r == '0 && !first_row_r)
    else $error("column did not wrap after end of row");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_r))
    else $error("front stage lost a stalled pixel");

  a_eol_tail: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && (eol_r == $past(s1_r.last)))
    else $error("result not loaded when front stage advanced");
`endif

endmodule

`default_nettype wire

### tb/error_diffusion_halftone_unit_test.sv
// Testbench: random and directed pixel streams against a predicted dot stream for the halftone unit.

module error_diffusion_halftone_unit_test;
  import edh_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_CYCLES = 400;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct {
    logic [PIX_W-1:0] dot;
    logic             end_of_line;
  } dot_item_t;

  // Predicts the dot stream and checks it against the block
  class halftone_scoreboard;
    int unsigned threshold;
    int unsigned line_width;
    int          row_errors[MAX_WIDTH];
    int          right_err;
    int          below_left_err;
    int          below_err;
    int unsigned column;
    bit          in_first_row;
    dot_item_t   expected_dots[$];
    int          errors;
    int          accepted;
    int          checked;
    int          reg_writes;

    function new();
      threshold      = THR_RESET;
      line_width     = LW_RESET;
      right_err      = 0;
      below_left_err = 0;
      below_err      = 0;
      column         = 0;
      in_first_row   = 1'b1;
      errors         = 0;
      accepted       = 0;
      checked        = 0;
      reg_writes     = 0;
      foreach (row_errors[i]) row_errors[i] = 0;
    endfunction

    function int clamp_err(int v);
      if (v > 511) return 511;
      if (v < -512) return -512;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == REG_THRESHOLD) threshold = data[THR_W-1:0];
      else if (idx == REG_LINE_WIDTH) line_width = data[LW_W-1:0];
    endfunction

    // Work out the dot for one accepted pixel and advance the error state
    function void note_pixel(logic [PIX_W-1:0] pix, logic sof);
      int unsigned w;
      int unsigned x;
      bit          last;
      int          above;
      int          v;
      int          e;
      dot_item_t   item;
      w = line_width;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      accepted++;
      if (sof) begin
        column         = 0;
        right_err      = 0;
        below_left_err = 0;
        below_err      = 0;
        in_first_row   = 1'b1;
      end
      x = column;
      if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;
      last  = (x + 1 >= w);
      above = in_first_row ? 0 : row_errors[x];
      v     = int'(pix) + right_err + above;
      if (v > int'(threshold)) begin
        item.dot = DOT_WHITE;
        e = v - 255;
      end else begin
        item.dot = DOT_BLACK;
        e = v;
      end
      if (x > 0) row_errors[x-1] = clamp_err(below_left_err + e * 3 / 16);
      below_left_err = clamp_err(below_err + e * 5 / 16);
      below_err      = clamp_err(e / 16);
      right_err      = clamp_err(e * 7 / 16);
      if (last) begin
        row_errors[x]  = below_left_err;
        right_err      = 0;
        below_left_err = 0;
        below_err      = 0;
        in_first_row   = 1'b0;
        column         = 0;
      end else begin
        column = x + 1;
      end
      item.end_of_line = last;
      expected_dots.push_back(item);
    endfunction

    function void check_dot(logic [PIX_W-1:0] dot, logic eol);
      dot_item_t exp_item;
      if (expected_dots.size() == 0) begin
        $error("unexpected result: dot %0d end_of_line %0d", dot, eol);
        errors++;
        return;
      end
      exp_item = expected_dots.pop_front();
      checked++;
      if (dot !== exp_item.dot) begin
        $error("dot: expected %0d, actual %0d", exp_item.dot, dot);
        errors++;
      end
      if (eol !== exp_item.end_of_line) begin
        $error("end_of_line: expected %0d, actual %0d", exp_item.end_of_line, eol);
        errors++;
      end
    endfunction

    function int pending();
      return expected_dots.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  edh_in_if  in_ch();
  edh_out_if out_ch();
  edh_cfg_if cfg_ch();

  error_diffusion_halftone_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  halftone_scoreboard sb;

  int          tx_idle_pct;
  int          rx_idle_pct;
  int          stall_mark;
  int          stall_left;
  bit          stall_done;
  int          cycles;
  int          items_sent;
  int unsigned cur_thr;
  int unsigned cur_width;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sample transfers on every channel
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_pixel(in_ch.pixel, in_ch.start_of_frame);
      if (out_ch.valid && out_ch.ready) sb.check_dot(out_ch.dot, out_ch.end_of_line);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!stall_done && sb.accepted >= stall_mark) begin
      out_ch.ready <= 1'b0;
      stall_left   <= STALL_CYCLES;
      stall_done   <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function int unsigned eff_width(int unsigned raw);
    if (raw < 2) return 2;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return raw;
  endfunction

  // Offer one pixel, with random idle cycles first; called at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pixel          <= pix;
    in_ch.start_of_frame <= sof;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Write one register; called at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_THRESHOLD) cur_thr = data[THR_W-1:0];
    else if (idx == REG_LINE_WIDTH) cur_width = eff_width(data[LW_W-1:0]);
  endtask

  // Stop offering and let every expected dot arrive
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    int t;
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: begin
        t = int'(cur_thr) + $urandom_range(8) - 4;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[PIX_W-1:0];
      end
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 55) return CFG_DATA_W'($urandom_range(16, 2));
    if (r < 75) return CFG_DATA_W'($urandom_range(64, 17));
    if (r < 83) return CFG_DATA_W'($urandom_range(1, 0));
    if (r < 90) return CFG_DATA_W'($urandom_range(2047, 1024));
    return CFG_DATA_W'($urandom_range(1023, 65));
  endfunction

  initial begin
    int                    n;
    int                    random_start;
    bit                    new_frame;
    bit                    first_c;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] tdata;

    sb                   = new();
    rst_n                = 1'b0;
    cycles               = 0;
    items_sent           = 0;
    stall_mark           = 32'h7fffffff;
    stall_left           = 0;
    stall_done           = 1'b0;
    tx_idle_pct          = 16;
    rx_idle_pct          = 61;
    cur_thr              = THR_RESET;
    cur_width            = LW_RESET;
    first_c              = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.pixel          = '0;
    in_ch.start_of_frame = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: two full rows at width 4, extremes around the threshold
    write_reg(REG_LINE_WIDTH, 11'd4);
    write_reg(REG_THRESHOLD, 11'd128);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd1, 1'b0);
    drain();

    // Wider line needs a fresh frame; stop part-way into the second row
    write_reg(REG_LINE_WIDTH, 11'd5);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd170, 1'b0);
    send_pixel(8'd85, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd245, 1'b0);
    drain();

    // Narrow the line inside a row: the next pixel ends it at once
    write_reg(REG_LINE_WIDTH, 11'd2);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd64, 1'b0);
    send_pixel(8'd192, 1'b0);
    drain();

    // Widths below the minimum act as two
    write_reg(REG_LINE_WIDTH, 11'd0);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd155, 1'b0);
    drain();
    write_reg(REG_LINE_WIDTH, 11'd1);
    send_pixel(8'd30, 1'b0);
    send_pixel(8'd225, 1'b0);
    drain();

    // Threshold extremes; upper data bits are dropped
    write_reg(REG_THRESHOLD, 11'h700);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd1, 1'b0);
    drain();
    write_reg(REG_THRESHOLD, 11'h0FF);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd254, 1'b0);
    drain();

    // Spare indexes are ignored; oversized width clamps to the store depth
    write_reg(REG_SPARE_A, 11'h7FF);
    write_reg(REG_SPARE_B, 11'h555);
    write_reg(REG_LINE_WIDTH, 11'h7FF);
    write_reg(REG_THRESHOLD, 11'd128);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    drain();

    // Random phases, each with its own settings
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      if (items_sent - random_start < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 16;
        rx_idle_pct = 61;
      end else if (items_sent - random_start < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 61;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (first_c) begin
          stall_mark = sb.accepted + 40;
          first_c    = 1'b0;
        end
      end

      if ($urandom_range(9) < 7) begin
        case ($urandom_range(5))
          0: tdata = 11'd0;
          1: tdata = 11'd255;
          default: tdata = CFG_DATA_W'($urandom_range(2047));
        endcase
        write_reg(REG_THRESHOLD, tdata);
      end
      new_frame = ($urandom_range(9) < 4);
      if ($urandom_range(9) < 8) begin
        wdata = pick_width();
        // A wider line would read store entries never written in this frame
        if (eff_width(wdata) > cur_width) new_frame = 1'b1;
        write_reg(REG_LINE_WIDTH, wdata);
      end
      if ($urandom_range(19) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(3, 2)), CFG_DATA_W'($urandom_range(2047)));
      end

      n = $urandom_range(200, 80);
      for (int i = 0; i < n; i++) begin
        send_pixel(pick_pixel(), (i == 0 && new_frame) || ($urandom_range(999) < 15));
      end
    end
    drain();
    repeat (10) @(posedge clk);

    $display("halftone run: %0d pixels sent, %0d dots checked, %0d register writes",
             items_sent, sb.checked, sb.reg_writes);
    $display("covered width clamps, mid-row narrowing, threshold extremes and a long output stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d dots outstanding", sb.errors, sb.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
